### sv/ddpi_pkg.sv
// Shared constants, types and helper functions for the differential drive PI controller.
// No dependencies; every other file except ddpi_cmd_if imports this package.
package ddpi_pkg;

    // Fixed point and geometry
    localparam int FRAC_BITS   = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int HALF_TRACK  = 5;
    // Right ratio error is scaled by four, done as a shift.
    localparam int RATIO_ERR_SHIFT = 2;

    // Data widths
    localparam int CFG_W   = 16;
    localparam int GAIN_W  = 12;
    localparam int SPEED_W = 24;
    localparam int PWM_W   = 16;
    localparam int MEAN_W  = 32;
    localparam int RATIO_W = 16;
    localparam int WERR_W  = 37;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int CFG_ADDR_W = 3;

    // Input kinds
    localparam logic [2:0] KIND_CMD    = 3'd0;
    localparam logic [2:0] KIND_LEFT   = 3'd1;
    localparam logic [2:0] KIND_RIGHT  = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_UPDATE = 3'd4;

    // Command codes
    localparam logic [2:0] CMD_IDLE     = 3'd0;
    localparam logic [2:0] CMD_STRAIGHT = 3'd1;
    localparam logic [2:0] CMD_RIGHT    = 3'd2;
    localparam logic [2:0] CMD_LEFT     = 3'd3;

    // Active modes
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_STRAIGHT = 2'd1;
    localparam logic [1:0] MODE_RIGHT    = 2'd2;
    localparam logic [1:0] MODE_LEFT     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CRUISE_SPEED    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRUISE_PWM      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P          = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I          = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P_TURN     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I_TURN     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_PER_COUNT = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_PWM_PER_SPEED   = 3'd7;

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

    // Saturate a nonnegative product to 24 bits.
    function automatic logic [SPEED_W-1:0] sat24_prod(input logic signed [PROD_W-1:0] v);
        if (v > $signed(PROD_W'(24'hFFFFFF))) begin
            return '1;
        end
        return v[SPEED_W-1:0];
    endfunction

    // Saturate a quotient to 24 bits.
    function automatic logic [SPEED_W-1:0] sat24_quot(input logic [DIV_NUM_W-1:0] v);
        if (v > DIV_NUM_W'(24'hFFFFFF)) begin
            return '1;
        end
        return v[SPEED_W-1:0];
    endfunction

    // PWM width from a product scaled by 2F fraction bits, saturated to 16 bits.
    function automatic logic [PWM_W-1:0] width_of(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] s;
        s = PROD_W'(v >>> (2 * FRAC_BITS));
        if (s > PROD_W'(16'hFFFF)) begin
            return '1;
        end
        return s[PWM_W-1:0];
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [MEAN_W-1:0] clamp32(input logic signed [PROD_W-1:0] v);
        if (v > $signed(PROD_W'(32'h7FFFFFFF))) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -$signed(PROD_W'(33'h080000000))) begin
            return 32'sh80000000;
        end
        return v[MEAN_W-1:0];
    endfunction

endpackage

### sv/ddpi_cmd_if.sv
// Request channel: one input item with valid/ready handshake.
// Uses no package; its widths are written out.
interface ddpi_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  command_mode;
    logic [15:0] command_arg;

    modport source (output valid, kind, command_mode, command_arg, input ready);
    modport sink (input valid, kind, command_mode, command_arg, output ready);
endinterface

### sv/ddpi_res_if.sv
// Result channel: PWM widths, run flags, mode and fault with valid/ready handshake.
// Depends on ddpi_pkg.
interface ddpi_res_if;
    import ddpi_pkg::*;
    logic             valid;
    logic             ready;
    logic [PWM_W-1:0] left_width;
    logic [PWM_W-1:0] right_width;
    logic             left_on;
    logic             right_on;
    logic [1:0]       active_mode;
    logic             fault;

    modport source (output valid, left_width, right_width, left_on, right_on,
                    active_mode, fault, input ready);
    modport sink (input valid, left_width, right_width, left_on, right_on,
                  active_mode, fault, output ready);
endinterface

### sv/differential_drive_pi_speed_control.sv
// Differential drive PI speed controller: a sequencer driving one registered multiplier
// and the shared iterative divider (ddpi_div). Edges, ticks and straight commands need no
// division; a turn and a control update each wait on up to three divider runs. One request
// is processed at a time; the next is taken as soon as the sequencer is idle, while a
// finished result may still wait in its register. Reset (synchronous, active low) restores
// the register defaults, mode idle, wheels off.
module differential_drive_pi_speed_control (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ddpi_cmd_if.sink                     i_cmd,
    ddpi_res_if.source                   o_res,
    input  logic                         i_cfg_we,
    input  logic [ddpi_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ddpi_pkg::CFG_W-1:0]   i_cfg_data
);
    import ddpi_pkg::*;

    // Sequencer states
    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_DISPATCH = 5'd1;
    localparam logic [4:0] ST_T_DIV1   = 5'd2;
    localparam logic [4:0] ST_T_WAIT1  = 5'd3;
    localparam logic [4:0] ST_T_W1     = 5'd4;
    localparam logic [4:0] ST_T_RWAIT  = 5'd5;
    localparam logic [4:0] ST_T_DIV2   = 5'd6;
    localparam logic [4:0] ST_T_WAIT2  = 5'd7;
    localparam logic [4:0] ST_T_W2     = 5'd8;
    localparam logic [4:0] ST_U_START  = 5'd9;
    localparam logic [4:0] ST_U_SPD    = 5'd10;
    localparam logic [4:0] ST_U_RS     = 5'd11;
    localparam logic [4:0] ST_U_RDIV   = 5'd12;
    localparam logic [4:0] ST_U_RWAIT  = 5'd13;
    localparam logic [4:0] ST_PI0      = 5'd14;
    localparam logic [4:0] ST_PI1      = 5'd15;
    localparam logic [4:0] ST_PI2      = 5'd16;
    localparam logic [4:0] ST_PI3      = 5'd17;
    localparam logic [4:0] ST_PI4      = 5'd18;
    localparam logic [4:0] ST_PI5      = 5'd19;
    localparam logic [4:0] ST_U_NEXT   = 5'd20;
    localparam logic [4:0] ST_DONE     = 5'd21;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Sequencer and captured request
    logic [4:0]  r_state;
    logic        r_side;
    logic [2:0]  r_kind;
    logic [2:0]  r_cmd_mode;
    logic [15:0] r_arg;

    // Configuration registers
    logic [CFG_W-1:0]  r_cruise_speed;
    logic [CFG_W-1:0]  r_cruise_pwm;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_p_turn;
    logic [GAIN_W-1:0] r_gain_i_turn;
    logic [GAIN_W-1:0] r_speed_per_count;
    logic [GAIN_W-1:0] r_pwm_per_speed;

    // Controller state
    logic [1:0]               r_mode;
    logic [COUNT_WIDTH-1:0]   r_left_edges;
    logic [COUNT_WIDTH-1:0]   r_right_edges;
    logic [COUNT_WIDTH-1:0]   r_sample_count;
    logic signed [MEAN_W-1:0] r_left_mean;
    logic signed [MEAN_W-1:0] r_right_mean;
    logic [SPEED_W-1:0]       r_left_target;
    logic [SPEED_W-1:0]       r_right_target;
    logic [SPEED_W-1:0]       r_left_speed;
    logic [SPEED_W-1:0]       r_right_speed;
    logic [RATIO_W-1:0]       r_wheel_ratio;
    logic [PWM_W-1:0]         r_left_pwm;
    logic [PWM_W-1:0]         r_right_pwm;
    logic                     r_left_on;
    logic                     r_right_on;
    logic                     r_fault;

    // Arithmetic registers
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_tot;
    logic signed [WERR_W-1:0] r_werr;
    logic signed [MEAN_W-1:0] r_err;
    logic                     r_neg;

    // Result register
    logic             r_ovalid;
    logic [PWM_W-1:0] r_o_left_width;
    logic [PWM_W-1:0] r_o_right_width;
    logic             r_o_left_on;
    logic             r_o_right_on;
    logic [1:0]       r_o_mode;
    logic             r_o_fault;

    // Combinational datapath
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic                      in_accept;
    logic                      ratio_mode;
    logic [SPEED_W-1:0]        own_speed;
    logic [SPEED_W-1:0]        other_speed;
    logic [SPEED_W-1:0]        own_target;
    logic signed [MEAN_W-1:0]  own_mean;
    logic [PWM_W-1:0]          own_pwm;
    logic [GAIN_W-1:0]         gain_p_sel;
    logic [GAIN_W-1:0]         gain_i_sel;
    logic [SPEED_W-1:0]        spd_now;
    logic [SPEED_W-1:0]        quot_sat;
    logic [16:0]               out_rad;
    logic [15:0]               in_rad;
    logic signed [PROD_W-1:0]  acc;
    logic [PROD_W-1:0]         acc_mag;
    logic signed [PROD_W-1:0]  q_signed;
    logic signed [WERR_W-1:0]  ratio_err;
    logic signed [PROD_W-1:0]  tot_sum;
    logic [PROD_W-1:0]         tot_mag;
    logic [PROD_W-1:0]         tot_rnd;
    logic signed [32:0]        step;
    logic signed [32:0]        pwm_sum;
    logic [PWM_W-1:0]          pwm_new;

    assign in_accept   = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);

    // Per-wheel selection for the wheel being worked on.
    always_comb begin
        ratio_mode  = r_side ? (r_mode == MODE_RIGHT) : (r_mode == MODE_LEFT);
        own_speed   = r_side ? r_right_speed : r_left_speed;
        other_speed = r_side ? r_left_speed : r_right_speed;
        own_target  = r_side ? r_right_target : r_left_target;
        own_mean    = r_side ? r_right_mean : r_left_mean;
        own_pwm     = r_side ? r_right_pwm : r_left_pwm;
        gain_p_sel  = ratio_mode ? r_gain_p_turn : r_gain_p;
        gain_i_sel  = ratio_mode ? r_gain_i_turn : r_gain_i;
        spd_now     = sat24_prod(r_prod);
        quot_sat    = sat24_quot(div_rsp.quot);
        out_rad     = {1'b0, r_arg} + 17'(HALF_TRACK);
        in_rad      = r_arg - 16'(HALF_TRACK);
    end

    // PI arithmetic: running mean accumulate, ratio error, rounded step and clamp.
    always_comb begin
        acc      = $signed(PROD_W'(r_err)) + r_prod;
        acc_mag  = acc[PROD_W-1] ? PROD_W'(-acc) : PROD_W'(acc);
        q_signed = r_neg ? -$signed({3'b0, div_rsp.quot}) : $signed({3'b0, div_rsp.quot});
        ratio_err = $signed({{(WERR_W - RATIO_W){1'b0}}, r_wheel_ratio})
                  - $signed({4'b0, div_rsp.quot[32:0]});
        if (r_side) begin
            ratio_err = ratio_err <<< RATIO_ERR_SHIFT;
        end
        tot_sum = r_tot + r_prod;
        tot_mag = tot_sum[PROD_W-1] ? PROD_W'(-tot_sum) : PROD_W'(tot_sum);
        tot_rnd = (tot_mag + (PROD_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        step    = $signed({2'b0, tot_rnd[30:0]});
        pwm_sum = $signed({17'b0, own_pwm}) + (tot_sum[PROD_W-1] ? -step : step);
        if (pwm_sum < 0) begin
            pwm_new = '0;
        end else if (pwm_sum > 33'sd65535) begin
            pwm_new = '1;
        end else begin
            pwm_new = pwm_sum[PWM_W-1:0];
        end
    end

    // Multiplier operand selection per sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DISPATCH: begin
                mul_a = $signed(MUL_A_W'(r_cruise_speed));
                mul_b = $signed(MUL_B_W'(out_rad));
            end
            ST_T_WAIT1, ST_T_WAIT2: begin
                mul_a = $signed(MUL_A_W'(quot_sat));
                mul_b = $signed(MUL_B_W'(r_pwm_per_speed));
            end
            ST_T_RWAIT: begin
                mul_a = $signed(MUL_A_W'(r_cruise_speed));
                mul_b = $signed(MUL_B_W'(in_rad));
            end
            ST_U_START: begin
                mul_a = $signed(MUL_A_W'(r_side ? r_right_edges : r_left_edges));
                mul_b = $signed(MUL_B_W'(r_speed_per_count));
            end
            ST_U_SPD: begin
                mul_a = $signed(MUL_A_W'(r_right_edges));
                mul_b = $signed(MUL_B_W'(r_speed_per_count));
            end
            ST_PI0: begin
                mul_a = MUL_A_W'(own_mean);
                mul_b = $signed(MUL_B_W'(r_sample_count - 1'b1));
            end
            ST_PI3: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = $signed(MUL_B_W'(gain_p_sel));
            end
            ST_PI4: begin
                mul_a = MUL_A_W'(own_mean);
                mul_b = $signed(MUL_B_W'(gain_i_sel));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider requests per sequencer step.
    always_comb begin
        div_req = '0;
        case (r_state)
            ST_T_DIV1, ST_T_DIV2: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NUM_W'(r_prod[DIV_NUM_W-1:0]);
                div_req.divisor  = DIV_DEN_W'(r_arg);
            end
            ST_T_W1: begin
                div_req.start    = (r_arg > 16'(HALF_TRACK));
                div_req.dividend = DIV_NUM_W'({in_rad, {FRAC_BITS{1'b0}}});
                div_req.divisor  = DIV_DEN_W'(out_rad);
            end
            ST_U_RDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NUM_W'({own_speed, {FRAC_BITS{1'b0}}});
                div_req.divisor  = other_speed;
            end
            ST_PI1: begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_mag[DIV_NUM_W-1:0];
                div_req.divisor  = DIV_DEN_W'(r_sample_count);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    ddpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Registered multiplier.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise_speed    <= 16'd8320;
            r_cruise_pwm      <= 16'd180;
            r_gain_p          <= 12'd512;
            r_gain_i          <= 12'd256;
            r_gain_p_turn     <= 12'd1280;
            r_gain_i_turn     <= 12'd1280;
            r_speed_per_count <= 12'd335;
            r_pwm_per_speed   <= 12'd1536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CRUISE_SPEED:    r_cruise_speed    <= i_cfg_data;
                CFG_CRUISE_PWM:      r_cruise_pwm      <= i_cfg_data;
                CFG_GAIN_P:          r_gain_p          <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:          r_gain_i          <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_P_TURN:     r_gain_p_turn     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I_TURN:     r_gain_i_turn     <= i_cfg_data[GAIN_W-1:0];
                CFG_SPEED_PER_COUNT: r_speed_per_count <= i_cfg_data[GAIN_W-1:0];
                CFG_PWM_PER_SPEED:   r_pwm_per_speed   <= i_cfg_data[GAIN_W-1:0];
                default:             r_pwm_per_speed   <= r_pwm_per_speed;
            endcase
        end
    end

    // Sequencer with controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_side         <= 1'b0;
            r_mode         <= MODE_IDLE;
            r_left_edges   <= '0;
            r_right_edges  <= '0;
            r_sample_count <= '0;
            r_left_mean    <= '0;
            r_right_mean   <= '0;
            r_left_target  <= '0;
            r_right_target <= '0;
            r_left_speed   <= '0;
            r_right_speed  <= '0;
            r_wheel_ratio  <= '0;
            r_left_pwm     <= '0;
            r_right_pwm    <= '0;
            r_left_on      <= 1'b0;
            r_right_on     <= 1'b0;
            r_fault        <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_kind     <= i_cmd.kind;
                        r_cmd_mode <= i_cmd.command_mode;
                        r_arg      <= i_cmd.command_arg;
                        r_fault    <= 1'b0;
                        r_state    <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    r_state <= ST_DONE;
                    case (r_kind)
                        KIND_CMD: begin
                            if (r_cmd_mode[2]) begin
                                // Unknown command: fault stop, counters kept.
                                r_fault    <= 1'b1;
                                r_left_on  <= 1'b0;
                                r_right_on <= 1'b0;
                                r_mode     <= MODE_IDLE;
                            end else begin
                                r_left_mean    <= '0;
                                r_right_mean   <= '0;
                                r_left_edges   <= '0;
                                r_right_edges  <= '0;
                                r_sample_count <= '0;
                                case (r_cmd_mode)
                                    CMD_IDLE: begin
                                        r_left_on  <= 1'b0;
                                        r_right_on <= 1'b0;
                                        r_mode     <= MODE_IDLE;
                                    end
                                    CMD_STRAIGHT: begin
                                        if (r_arg == '0) begin
                                            r_left_target  <= '0;
                                            r_right_target <= '0;
                                            r_left_on      <= 1'b0;
                                            r_right_on     <= 1'b0;
                                            r_mode         <= MODE_IDLE;
                                        end else begin
                                            r_left_target  <= SPEED_W'(r_cruise_speed);
                                            r_right_target <= SPEED_W'(r_cruise_speed);
                                            r_left_pwm     <= r_cruise_pwm;
                                            r_right_pwm    <= r_cruise_pwm;
                                            r_left_on      <= 1'b1;
                                            r_right_on     <= 1'b1;
                                            r_mode         <= MODE_STRAIGHT;
                                        end
                                    end
                                    default: begin
                                        if (r_arg == '0) begin
                                            // Zero radius turn.
                                            r_fault    <= 1'b1;
                                            r_left_on  <= 1'b0;
                                            r_right_on <= 1'b0;
                                            r_mode     <= MODE_IDLE;
                                        end else begin
                                            // Outer wheel: left on a right turn.
                                            r_side  <= (r_cmd_mode == CMD_LEFT);
                                            r_state <= ST_T_DIV1;
                                        end
                                    end
                                endcase
                            end
                        end
                        KIND_LEFT: begin
                            if (r_left_edges != COUNT_MAX) begin
                                r_left_edges <= r_left_edges + 1'b1;
                            end
                        end
                        KIND_RIGHT: begin
                            if (r_right_edges != COUNT_MAX) begin
                                r_right_edges <= r_right_edges + 1'b1;
                            end
                        end
                        KIND_TICK: begin
                            if (r_mode != MODE_IDLE && r_sample_count != COUNT_MAX) begin
                                r_sample_count <= r_sample_count + 1'b1;
                            end
                        end
                        KIND_UPDATE: begin
                            if (r_mode != MODE_IDLE) begin
                                r_side  <= 1'b0;
                                r_state <= ST_U_START;
                            end
                        end
                        default: begin
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                // Turn: outer target and width.
                ST_T_DIV1: begin
                    r_state <= ST_T_WAIT1;
                end
                ST_T_WAIT1: begin
                    if (div_rsp.done) begin
                        if (r_side) begin
                            r_right_target <= quot_sat;
                        end else begin
                            r_left_target <= quot_sat;
                        end
                        r_state <= ST_T_W1;
                    end
                end
                ST_T_W1: begin
                    if (r_side) begin
                        r_right_pwm <= width_of(r_prod);
                        r_right_on  <= 1'b1;
                    end else begin
                        r_left_pwm <= width_of(r_prod);
                        r_left_on  <= 1'b1;
                    end
                    if (r_arg > 16'(HALF_TRACK)) begin
                        r_state <= ST_T_RWAIT;
                    end else begin
                        // Radius inside the track: inner wheel stopped, ratio kept.
                        if (r_side) begin
                            r_left_target <= '0;
                            r_left_pwm    <= '0;
                            r_left_on     <= 1'b0;
                        end else begin
                            r_right_target <= '0;
                            r_right_pwm    <= '0;
                            r_right_on     <= 1'b0;
                        end
                        r_mode  <= r_cmd_mode[1:0];
                        r_state <= ST_DONE;
                    end
                end
                // Turn: wheel ratio, then inner target and width.
                ST_T_RWAIT: begin
                    if (div_rsp.done) begin
                        r_wheel_ratio <= div_rsp.quot[RATIO_W-1:0];
                        r_state       <= ST_T_DIV2;
                    end
                end
                ST_T_DIV2: begin
                    r_state <= ST_T_WAIT2;
                end
                ST_T_WAIT2: begin
                    if (div_rsp.done) begin
                        if (r_side) begin
                            r_left_target <= quot_sat;
                        end else begin
                            r_right_target <= quot_sat;
                        end
                        r_state <= ST_T_W2;
                    end
                end
                ST_T_W2: begin
                    if (r_side) begin
                        r_left_pwm <= width_of(r_prod);
                        r_left_on  <= 1'b1;
                    end else begin
                        r_right_pwm <= width_of(r_prod);
                        r_right_on  <= 1'b1;
                    end
                    r_mode  <= r_cmd_mode[1:0];
                    r_state <= ST_DONE;
                end
                // Update: measure this wheel and form its error.
                ST_U_START: begin
                    r_state <= ST_U_SPD;
                end
                ST_U_SPD: begin
                    if (r_side) begin
                        r_right_speed <= spd_now;
                    end else begin
                        r_left_speed <= spd_now;
                    end
                    if (!ratio_mode) begin
                        r_werr  <= $signed(WERR_W'(own_target)) - $signed(WERR_W'(spd_now));
                        r_state <= ST_PI0;
                    end else if (!r_side) begin
                        r_state <= (r_right_speed == '0) ? ST_U_RS : ST_U_RDIV;
                    end else if (r_left_speed == '0) begin
                        r_fault <= 1'b1;
                        r_state <= ST_U_NEXT;
                    end else begin
                        r_state <= ST_U_RDIV;
                    end
                end
                ST_U_RS: begin
                    // Right speed reloaded from its edge count.
                    r_right_speed <= spd_now;
                    if (spd_now == '0) begin
                        r_fault <= 1'b1;
                        r_state <= ST_U_NEXT;
                    end else begin
                        r_state <= ST_U_RDIV;
                    end
                end
                ST_U_RDIV: begin
                    r_state <= ST_U_RWAIT;
                end
                ST_U_RWAIT: begin
                    if (div_rsp.done) begin
                        r_werr  <= ratio_err;
                        r_state <= ST_PI0;
                    end
                end
                // PI loop: running mean of the error.
                ST_PI0: begin
                    r_err <= clamp32(PROD_W'(r_werr));
                    if (r_sample_count == '0) begin
                        r_fault <= 1'b1;
                        r_state <= ST_PI3;
                    end else begin
                        r_state <= ST_PI1;
                    end
                end
                ST_PI1: begin
                    r_neg   <= acc[PROD_W-1];
                    r_state <= ST_PI2;
                end
                ST_PI2: begin
                    if (div_rsp.done) begin
                        if (r_side) begin
                            r_right_mean <= clamp32(q_signed);
                        end else begin
                            r_left_mean <= clamp32(q_signed);
                        end
                        r_state <= ST_PI3;
                    end
                end
                // PI loop: proportional and integral terms, width update.
                ST_PI3: begin
                    r_state <= ST_PI4;
                end
                ST_PI4: begin
                    r_tot   <= r_prod;
                    r_state <= ST_PI5;
                end
                ST_PI5: begin
                    if (r_side) begin
                        r_right_pwm <= pwm_new;
                    end else begin
                        r_left_pwm <= pwm_new;
                    end
                    r_state <= ST_U_NEXT;
                end
                ST_U_NEXT: begin
                    if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= ST_U_START;
                    end else begin
                        r_left_edges  <= '0;
                        r_right_edges <= '0;
                        r_state       <= ST_DONE;
                    end
                end
                // Hand the result to the output register once it is free.
                ST_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid        <= 1'b1;
                        r_o_left_width  <= r_left_pwm;
                        r_o_right_width <= r_right_pwm;
                        r_o_left_on     <= r_left_on;
                        r_o_right_on    <= r_right_on;
                        r_o_mode        <= r_mode;
                        r_o_fault       <= r_fault;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.left_width  = r_o_left_width;
    assign o_res.right_width = r_o_right_width;
    assign o_res.left_on     = r_o_left_on;
    assign o_res.right_on    = r_o_right_on;
    assign o_res.active_mode = r_o_mode;
    assign o_res.fault       = r_o_fault;
endmodule

### sv/ddpi_div.sv
// Iterative restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on ddpi_pkg (widths and request/response structs).
module ddpi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddpi_pkg::t_div_req i_req,
    output ddpi_pkg::t_div_rsp o_rsp
);
    import ddpi_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;
    logic [DIV_DEN_W:0]   rem_nx;

    // One shift-and-subtract step.
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
        fits   = rem_sh >= {1'b0, r_den};
        rem_nx = fits ? rem_sh - {1'b0, r_den} : rem_sh;
    end

    // Control: start loads the operands, the last step raises done for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and the shifting dividend/quotient word.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= rem_nx[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
endmodule

### sv/ddpi_checker.sv
// Port-level checks for the differential drive PI controller, bound to the top level.
// Depends on ddpi_pkg for mode codes.
module ddpi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_left_width,
    input logic        i_left_on,
    input logic        i_right_on,
    input logic [1:0]  i_active_mode
);
    import ddpi_pkg::*;

    // A stalled result stays valid and keeps its left width.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_left_width))
        else $error("result changed while stalled");

    // An accepted request makes the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken back to back");

    // Idle mode means both wheels are off.
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_active_mode == MODE_IDLE |-> !i_left_on && !i_right_on)
        else $error("wheel running in idle mode");

    // The outer wheel of a turn is always running.
    a_outer_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_active_mode == MODE_RIGHT || i_active_mode == MODE_LEFT)
        |-> (i_active_mode == MODE_RIGHT) ? i_left_on : i_right_on)
        else $error("outer wheel off during turn");
endmodule

bind differential_drive_pi_speed_control ddpi_checker u_ddpi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_left_width  (o_res.left_width),
    .i_left_on     (o_res.left_on),
    .i_right_on    (o_res.right_on),
    .i_active_mode (o_res.active_mode)
);

### tb/tb_differential_drive_pi_speed_control.sv
// Self-checking testbench for differential_drive_pi_speed_control.
// Depends on ddpi_pkg and the ddpi_cmd_if / ddpi_res_if interfaces; predicts every
// result with its own model of the controller and checks it field by field.
`timescale 1ns / 100ps

module tb_differential_drive_pi_speed_control;
    import ddpi_pkg::*;

    localparam int LW = 0;
    localparam int RW = 1;
    localparam int STALL_MAX = 13;

    typedef struct packed {
        logic [PWM_W-1:0] left_width;
        logic [PWM_W-1:0] right_width;
        logic             left_on;
        logic             right_on;
        logic [1:0]       active_mode;
        logic             fault;
    } t_drive_status;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_data;

    ddpi_cmd_if cmd_ch ();
    ddpi_res_if res_ch ();

    differential_drive_pi_speed_control u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // Controller state as the predictor sees it.
    logic [15:0] cfg_val [8];
    logic [1:0]  drv_mode;
    longint      edges [2];
    longint      ticks;
    int          mean_err [2];
    longint      target [2];
    longint      speed [2];
    longint      ratio;
    longint      pwm [2];
    logic        wheel_on [2];
    logic        fault_now;

    t_drive_status status_q [$];
    int errors;
    int n_sent;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint sat_to(input longint v, input longint top);
        return (v > top) ? top : v;
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint wheel_speed(input longint n);
        return sat_to(n * longint'(cfg_val[CFG_SPEED_PER_COUNT]), 64'hFFFFFF);
    endfunction

    function automatic longint start_width(input longint t);
        return sat_to((t * longint'(cfg_val[CFG_PWM_PER_SPEED])) >>> (2 * FRAC_BITS), 64'hFFFF);
    endfunction

    function automatic void reset_state();
        cfg_val[CFG_CRUISE_SPEED] = 16'd8320;
        cfg_val[CFG_CRUISE_PWM] = 16'd180;
        cfg_val[CFG_GAIN_P] = 16'd512;
        cfg_val[CFG_GAIN_I] = 16'd256;
        cfg_val[CFG_GAIN_P_TURN] = 16'd1280;
        cfg_val[CFG_GAIN_I_TURN] = 16'd1280;
        cfg_val[CFG_SPEED_PER_COUNT] = 16'd335;
        cfg_val[CFG_PWM_PER_SPEED] = 16'd1536;
        drv_mode = MODE_IDLE;
        ticks = 0;
        ratio = 0;
        for (int w = 0; w < 2; w++) begin
            edges[w] = 0;
            mean_err[w] = 0;
            target[w] = 0;
            speed[w] = 0;
            pwm[w] = 0;
            wheel_on[w] = 1'b0;
        end
    endfunction

    function automatic void clear_run();
        mean_err[LW] = 0;
        mean_err[RW] = 0;
        edges[LW] = 0;
        edges[RW] = 0;
        ticks = 0;
    endfunction

    // One wheel's PI step: running-mean integral, rounded step, clamped width.
    function automatic void pi_step(input int w, input longint err_in, input longint gp,
                                    input longint gi);
        longint err;
        longint total;
        longint mag;
        longint q;
        longint nw;
        err = clamp_s32(err_in);
        if (ticks == 0) begin
            fault_now = 1'b1;
        end else begin
            mean_err[w] = int'(clamp_s32((err + longint'(mean_err[w]) * (ticks - 1)) / ticks));
        end
        total = gp * err + gi * longint'(mean_err[w]);
        mag = (total < 0) ? -total : total;
        mag = (mag + (64'sd1 << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
        q = (total < 0) ? -mag : mag;
        nw = pwm[w] + q;
        if (nw < 0) begin
            nw = 0;
        end
        if (nw > 65535) begin
            nw = 65535;
        end
        pwm[w] = nw;
    endfunction

    // Turn setup: outer wheel from the radius; inner wheel stopped on tight radii.
    function automatic void start_turn(input longint r, input int outer, input logic [1:0] m);
        longint out_rad;
        longint in_rad;
        int inner;
        inner = 1 - outer;
        out_rad = r + HALF_TRACK;
        if (r == 0) begin
            fault_now = 1'b1;
            wheel_on[LW] = 1'b0;
            wheel_on[RW] = 1'b0;
            drv_mode = MODE_IDLE;
            return;
        end
        target[outer] = sat_to(longint'(cfg_val[CFG_CRUISE_SPEED]) * out_rad / r, 64'hFFFFFF);
        pwm[outer] = start_width(target[outer]);
        wheel_on[outer] = 1'b1;
        if (out_rad < 2 * HALF_TRACK + 1) begin
            target[inner] = 0;
            pwm[inner] = 0;
            wheel_on[inner] = 1'b0;
        end else begin
            in_rad = out_rad - 2 * HALF_TRACK;
            ratio = ((in_rad << FRAC_BITS) / out_rad) & 64'hFFFF;
            target[inner] = sat_to(longint'(cfg_val[CFG_CRUISE_SPEED]) * in_rad / r,
                                   64'hFFFFFF);
            pwm[inner] = start_width(target[inner]);
            wheel_on[inner] = 1'b1;
        end
        drv_mode = m;
    endfunction

    function automatic void run_command(input logic [2:0] m, input logic [15:0] arg);
        if (m > CMD_LEFT) begin
            fault_now = 1'b1;
            wheel_on[LW] = 1'b0;
            wheel_on[RW] = 1'b0;
            drv_mode = MODE_IDLE;
            return;
        end
        clear_run();
        case (m)
            CMD_IDLE: begin
                wheel_on[LW] = 1'b0;
                wheel_on[RW] = 1'b0;
                drv_mode = MODE_IDLE;
            end
            CMD_STRAIGHT: begin
                if (arg == 0) begin
                    target[LW] = 0;
                    target[RW] = 0;
                    wheel_on[LW] = 1'b0;
                    wheel_on[RW] = 1'b0;
                    drv_mode = MODE_IDLE;
                end else begin
                    target[LW] = cfg_val[CFG_CRUISE_SPEED];
                    target[RW] = cfg_val[CFG_CRUISE_SPEED];
                    pwm[LW] = cfg_val[CFG_CRUISE_PWM];
                    pwm[RW] = cfg_val[CFG_CRUISE_PWM];
                    wheel_on[LW] = 1'b1;
                    wheel_on[RW] = 1'b1;
                    drv_mode = MODE_STRAIGHT;
                end
            end
            CMD_RIGHT: start_turn(arg, LW, MODE_RIGHT);
            default: start_turn(arg, RW, MODE_LEFT);
        endcase
    endfunction

    // Control update: left loop, then right loop; inner wheel tracks the ratio.
    function automatic void control_update();
        longint cur;
        speed[LW] = wheel_speed(edges[LW]);
        if (drv_mode != MODE_LEFT) begin
            pi_step(LW, target[LW] - speed[LW], cfg_val[CFG_GAIN_P], cfg_val[CFG_GAIN_I]);
        end else begin
            if (speed[RW] == 0) begin
                speed[RW] = wheel_speed(edges[RW]);
            end
            if (speed[RW] == 0) begin
                fault_now = 1'b1;
            end else begin
                cur = (speed[LW] << FRAC_BITS) / speed[RW];
                pi_step(LW, ratio - cur, cfg_val[CFG_GAIN_P_TURN], cfg_val[CFG_GAIN_I_TURN]);
            end
        end
        speed[RW] = wheel_speed(edges[RW]);
        if (drv_mode != MODE_RIGHT) begin
            pi_step(RW, target[RW] - speed[RW], cfg_val[CFG_GAIN_P], cfg_val[CFG_GAIN_I]);
        end else if (speed[LW] == 0) begin
            fault_now = 1'b1;
        end else begin
            cur = (speed[RW] << FRAC_BITS) / speed[LW];
            pi_step(RW, (ratio - cur) <<< RATIO_ERR_SHIFT, cfg_val[CFG_GAIN_P_TURN],
                    cfg_val[CFG_GAIN_I_TURN]);
        end
        edges[LW] = 0;
        edges[RW] = 0;
    endfunction

    function automatic t_drive_status predict_status(input logic [2:0] kind,
                                                     input logic [2:0] m,
                                                     input logic [15:0] arg);
        t_drive_status s;
        fault_now = 1'b0;
        case (kind)
            KIND_CMD:    run_command(m, arg);
            KIND_LEFT:   if (edges[LW] < 65535) edges[LW]++;
            KIND_RIGHT:  if (edges[RW] < 65535) edges[RW]++;
            KIND_TICK:   if (drv_mode != MODE_IDLE && ticks < 65535) ticks++;
            KIND_UPDATE: if (drv_mode != MODE_IDLE) control_update();
            default: ;
        endcase
        s.left_width = pwm[LW][15:0];
        s.right_width = pwm[RW][15:0];
        s.left_on = wheel_on[LW];
        s.right_on = wheel_on[RW];
        s.active_mode = drv_mode;
        s.fault = fault_now;
        return s;
    endfunction

    // Send one request after a random gap; valid stays high until the next gap.
    task automatic send_request(input logic [2:0] kind, input logic [2:0] m,
                                input logic [15:0] arg);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= kind;
        cmd_ch.command_mode <= m;
        cmd_ch.command_arg <= arg;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        status_q.push_back(predict_status(kind, m, arg));
        n_sent++;
    endtask

    // Wait until every expected result has come back, then let the block settle.
    task automatic drain_results();
        if (cmd_ch.valid) begin
            cmd_ch.valid <= 1'b0;
        end
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Write enable is left high; the caller drops it after its last write.
    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        cfg_val[idx] = (idx <= CFG_CRUISE_PWM) ? val : (val & 16'h0FFF);
    endtask

    // Result checker with random back-pressure.
    initial begin
        t_drive_status want;
        t_drive_status got;
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            got.left_width = res_ch.left_width;
            got.right_width = res_ch.right_width;
            got.left_on = res_ch.left_on;
            got.right_on = res_ch.right_on;
            got.active_mode = res_ch.active_mode;
            got.fault = res_ch.fault;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, got);
            end else begin
                want = status_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    // Directed: every command, special turn radii, faults, noise kinds.
    task automatic test_directed_commands();
        send_request(KIND_UPDATE, CMD_IDLE, 16'h0);
        send_request(KIND_TICK, CMD_IDLE, 16'h0);
        send_request(KIND_CMD, CMD_STRAIGHT, 16'hFFFF);
        send_request(KIND_UPDATE, CMD_IDLE, 16'h0);
        send_request(KIND_TICK, CMD_IDLE, 16'h0);
        send_request(KIND_LEFT, CMD_IDLE, 16'h0);
        send_request(KIND_UPDATE, CMD_IDLE, 16'h0);
        send_request(KIND_CMD, CMD_RIGHT, 16'd0);
        send_request(KIND_CMD, CMD_RIGHT, 16'd5);
        send_request(KIND_CMD, CMD_LEFT, 16'd6);
        send_request(KIND_TICK, CMD_IDLE, 16'h0);
        send_request(KIND_UPDATE, CMD_IDLE, 16'h0);
        send_request(KIND_RIGHT, CMD_IDLE, 16'h0);
        send_request(KIND_UPDATE, CMD_IDLE, 16'h0);
        send_request(KIND_CMD, CMD_RIGHT, 16'hFFFF);
        send_request(KIND_TICK, CMD_IDLE, 16'h0);
        send_request(KIND_UPDATE, CMD_IDLE, 16'h0);
        send_request(KIND_CMD, 3'd4, 16'h1234);
        send_request(KIND_CMD, 3'd7, 16'h0);
        send_request(3'd5, 3'd7, 16'hFFFF);
        send_request(3'd7, CMD_IDLE, 16'h0);
        send_request(KIND_CMD, CMD_STRAIGHT, 16'd0);
        send_request(KIND_CMD, CMD_IDLE, 16'h0);
        drain_results();
    endtask

    // One well-formed drive run: a command, then rounds of edges, ticks and updates.
    task automatic drive_run(input int rounds);
        logic [2:0] m;
        logic [15:0] r;
        m = 3'($urandom_range(CMD_STRAIGHT, CMD_LEFT));
        case ($urandom_range(0, 3))
            0: r = 16'($urandom_range(1, 12));
            1: r = 16'($urandom);
            default: r = 16'($urandom_range(6, 400));
        endcase
        send_request(KIND_CMD, m, r);
        for (int k = 0; k < rounds; k++) begin
            repeat ($urandom_range(0, 2)) send_request(KIND_TICK, 3'($urandom), 16'($urandom));
            repeat ($urandom_range(0, 6)) send_request(KIND_LEFT, 3'($urandom), 16'($urandom));
            repeat ($urandom_range(0, 6)) send_request(KIND_RIGHT, 3'($urandom), 16'($urandom));
            send_request(KIND_UPDATE, 3'($urandom), 16'($urandom));
        end
    endtask

    // Random: mostly drive runs, some noise requests; one pause for a full drain.
    task automatic test_random_traffic(input int n_items);
        int first;
        logic paused;
        first = n_sent;
        paused = 1'b0;
        while (n_sent - first < n_items) begin
            if ($urandom_range(0, 5) == 0) begin
                send_request(3'($urandom), 3'($urandom), 16'($urandom));
            end else begin
                drive_run($urandom_range(1, 6));
            end
            if (!paused && n_sent - first >= n_items / 2) begin
                paused = 1'b1;
                cmd_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (status_q.size() != 0) @(posedge i_clk);
            end
        end
        drain_results();
    endtask

    // Register settings: extremes and random values, written only while idle.
    task automatic test_config_phase(input int setting);
        for (int i = 0; i < 8; i++) begin
            case (setting)
                0: write_cfg(CFG_ADDR_W'(i), 16'hFFFF);
                1: write_cfg(CFG_ADDR_W'(i), 16'h0000);
                default: write_cfg(CFG_ADDR_W'(i), 16'($urandom));
            endcase
        end
        if (setting == 1) begin
            write_cfg(CFG_CRUISE_SPEED, 16'd4000);
            write_cfg(CFG_SPEED_PER_COUNT, 16'd300);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        errors = 0;
        n_sent = 0;
        reset_state();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.kind <= KIND_CMD;
        cmd_ch.command_mode <= CMD_IDLE;
        cmd_ch.command_arg <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_commands();
        test_random_traffic(400);
        test_config_phase(0);
        test_random_traffic(200);
        test_config_phase(1);
        test_random_traffic(200);
        test_config_phase(2);
        test_random_traffic(250);
        test_config_phase(2);
        test_random_traffic(250);

        drain_results();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
